FILE: sv/dct_pkg.sv
// Shared types and constants for the connectivity table unit.
package dct_pkg;

    localparam int NODE_W = 9;
    localparam int CNT_W  = 9;
    localparam logic [CNT_W-1:0] NODE_COUNT_RST = 9'd256;

    localparam logic KIND_QUERY   = 1'b0;
    localparam logic KIND_CONNECT = 1'b1;

    typedef struct packed {
        logic              kind;
        logic [NODE_W-1:0] node_a;
        logic [NODE_W-1:0] node_b;
        logic              nodes_ok;
    } t_cmd;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_LOOKUP,
        ST_SCAN,
        ST_DRAIN
    } t_state;

endpackage

FILE: sv/dct_if.sv
// Valid/ready channel interfaces for request and result words.
interface dct_in_if;
    import dct_pkg::*;
    logic              valid;
    logic              ready;
    logic              kind;
    logic [NODE_W-1:0] node_a;
    logic [NODE_W-1:0] node_b;
    modport source (output valid, kind, node_a, node_b, input ready);
    modport sink   (input valid, kind, node_a, node_b, output ready);
endinterface

interface dct_out_if;
    logic valid;
    logic ready;
    logic connected;
    logic out_of_range;
    modport source (output valid, connected, out_of_range, input ready);
    modport sink   (input valid, connected, out_of_range, output ready);
endinterface

FILE: sv/dct_front.sv
// Front end: accepts request words, holds node_count, checks node range.
module dct_front #(
    parameter int NODES = 256
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic [dct_pkg::CNT_W-1:0] i_cfg_wr_data,
    input  logic                  i_init_busy,
    input  logic                  i_q_full,
    dct_in_if.sink                i_in,
    output logic                  o_push,
    output dct_pkg::t_cmd         o_cmd
);
    import dct_pkg::*;

    logic [CNT_W-1:0] r_node_count;
    logic             ok_a;
    logic             ok_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_count <= NODE_COUNT_RST;
        end else if (i_cfg_wr_en) begin
            r_node_count <= i_cfg_wr_data;
        end
    end

    // a node is usable when 1 <= n <= min(node_count, NODES)
    always_comb begin
        ok_a = (i_in.node_a != '0) && (CNT_W'(i_in.node_a) <= r_node_count)
            && (32'(i_in.node_a) <= 32'(NODES));
        ok_b = (i_in.node_b != '0) && (CNT_W'(i_in.node_b) <= r_node_count)
            && (32'(i_in.node_b) <= 32'(NODES));
    end

    assign i_in.ready     = !i_q_full && !i_init_busy;
    assign o_push         = i_in.valid && i_in.ready;
    assign o_cmd.kind     = i_in.kind;
    assign o_cmd.node_a   = i_in.node_a;
    assign o_cmd.node_b   = i_in.node_b;
    assign o_cmd.nodes_ok = ok_a && ok_b;

endmodule

FILE: sv/dct_queue.sv
// Two-entry command queue between front end and table engine.
module dct_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  dct_pkg::t_cmd i_cmd,
    input  logic          i_pop,
    output logic          o_full,
    output logic          o_empty,
    output dct_pkg::t_cmd o_cmd
);
    import dct_pkg::*;

    t_cmd       r_slot [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign o_cmd   = r_slot[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            r_count <= r_count + 2'(i_push) - 2'(i_pop);
        end
    end

endmodule

FILE: sv/dct_back.sv
// Table engine: label memory, init sweep, lookups and relabel scans.
module dct_back #(
    parameter int NODES = 256
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_q_empty,
    input  dct_pkg::t_cmd i_cmd,
    output logic          o_pop,
    output logic          o_init_busy,
    dct_out_if.source     o_out
);
    import dct_pkg::*;

    localparam int AW = (NODES > 1) ? $clog2(NODES) : 1;
    localparam int XW = (AW > NODE_W) ? AW : NODE_W;
    localparam logic [AW-1:0] LAST = AW'(NODES - 1);

    logic [AW-1:0] r_mem [NODES];
    logic [AW-1:0] r_rd_a;
    logic [AW-1:0] r_rd_b;

    t_state        r_state;
    t_state        n_state;
    logic [AW-1:0] r_idx;
    logic          r_pend;
    logic [AW-1:0] r_waddr;
    logic [AW-1:0] r_keep;
    logic [AW-1:0] r_drop;
    t_cmd          r_cmd;
    logic          r_out_valid;
    logic          r_connected;
    logic          r_oor;

    logic          rd_en_a;
    logic          rd_en_b;
    logic [AW-1:0] rd_addr_a;
    logic [AW-1:0] rd_addr_b;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [AW-1:0] wr_data;
    logic          out_load;
    logic          pop;
    logic [XW-1:0] a_m1;
    logic [XW-1:0] b_m1;

    assign a_m1 = XW'(i_cmd.node_a) - XW'(1);
    assign b_m1 = XW'(i_cmd.node_b) - XW'(1);

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_INIT: begin
                if (r_idx == LAST) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (!i_q_empty) n_state = ST_LOOKUP;
            end
            ST_LOOKUP: begin
                if (r_cmd.kind == KIND_QUERY) begin
                    if (!r_out_valid || o_out.ready) n_state = ST_IDLE;
                end else if (r_cmd.nodes_ok && (r_rd_a != r_rd_b)) begin
                    n_state = ST_SCAN;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_SCAN: begin
                if (r_idx == LAST) n_state = ST_DRAIN;
            end
            ST_DRAIN: n_state = ST_IDLE;
            default:  n_state = ST_INIT;
        endcase
    end

    always_comb begin
        pop       = 1'b0;
        rd_en_a   = 1'b0;
        rd_en_b   = 1'b0;
        rd_addr_a = a_m1[AW-1:0];
        rd_addr_b = b_m1[AW-1:0];
        wr_en     = 1'b0;
        wr_addr   = r_waddr;
        wr_data   = r_keep;
        out_load  = 1'b0;
        case (r_state)
            ST_INIT: begin
                wr_en   = 1'b1;
                wr_addr = r_idx;
                wr_data = r_idx;
            end
            ST_IDLE: begin
                pop     = !i_q_empty;
                rd_en_a = !i_q_empty;
                rd_en_b = !i_q_empty;
            end
            ST_LOOKUP: begin
                out_load = (r_cmd.kind == KIND_QUERY) && (!r_out_valid || o_out.ready);
            end
            ST_SCAN: begin
                rd_en_a   = 1'b1;
                rd_addr_a = r_idx;
                wr_en     = r_pend && (r_rd_a == r_drop);
            end
            ST_DRAIN: begin
                wr_en = r_pend && (r_rd_a == r_drop);
            end
            default: begin
                pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en_a) begin
            r_rd_a <= r_mem[rd_addr_a];
        end
        if (rd_en_b) begin
            r_rd_b <= r_mem[rd_addr_b];
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_cmd <= i_cmd;
        end
        if (r_state == ST_LOOKUP) begin
            r_keep <= r_rd_a;
            r_drop <= r_rd_b;
        end
        if (r_state == ST_SCAN) begin
            r_waddr <= r_idx;
        end
        if (out_load) begin
            r_connected <= r_cmd.nodes_ok && (r_rd_a == r_rd_b);
            r_oor       <= !r_cmd.nodes_ok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_INIT;
            r_idx       <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pend  <= (r_state == ST_SCAN);
            if (r_state == ST_INIT || r_state == ST_SCAN) begin
                r_idx <= r_idx + AW'(1);
            end else if (r_state == ST_LOOKUP) begin
                r_idx <= '0;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_pop              = pop;
    assign o_init_busy        = (r_state == ST_INIT);
    assign o_out.valid        = r_out_valid;
    assign o_out.connected    = r_connected;
    assign o_out.out_of_range = r_oor;

endmodule

FILE: sv/dynamic_connectivity_table_unit.sv
// Top level of the quick-find connectivity table unit.
//
// Request words arrive on i_in (kind, node_a, node_b), result words leave on
// o_out (connected, out_of_range). A query gives one result word, a connect
// gives none. i_cfg_wr_en/i_cfg_wr_data write node_count; the user must do so
// only while the unit idles, since the block itself does not enforce it.
// A front end checks node range and drops requests into a two-entry queue; an
// engine works through the queue against a one-write, two-read label memory.
// A query is popped, its two labels read, and the answer loaded into the result
// register. A connect whose nodes already share a label ends after the lookup;
// a real merge scans the whole label memory through one read port. A result
// waits in the output register while the receiver stalls; the queue keeps
// taking requests until it holds two, then i_in.ready drops.
//
// After reset the engine writes label i into entry i, one entry per cycle, so
// no request is accepted until that sweep is done. node_count resets to 256.
module dynamic_connectivity_table_unit #(
    parameter int NODES = 256
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_wr_en,
    input  logic [dct_pkg::CNT_W-1:0] i_cfg_wr_data,
    dct_in_if.sink                   i_in,
    dct_out_if.source                o_out
);
    import dct_pkg::*;

    logic init_busy;
    logic q_full;
    logic q_empty;
    logic push;
    logic pop;
    t_cmd push_cmd;
    t_cmd head_cmd;

    dct_front #(.NODES(NODES)) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_init_busy   (init_busy),
        .i_q_full      (q_full),
        .i_in          (i_in),
        .o_push        (push),
        .o_cmd         (push_cmd)
    );

    dct_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_cmd   (head_cmd)
    );

    dct_back #(.NODES(NODES)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_empty   (q_empty),
        .i_cmd       (head_cmd),
        .o_pop       (pop),
        .o_init_busy (init_busy),
        .o_out       (o_out)
    );

endmodule

FILE: dv/dct_link_checker.sv
// Connectivity checker: tracks component labels and compares each result word.
module dct_link_checker #(
    parameter int NODES = 256
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_wr_en,
    input  logic [dct_pkg::CNT_W-1:0] i_cfg_wr_data,
    dct_in_if                         i_req_mon,
    dct_out_if                        i_res_mon,
    output int                        o_fail_count,
    output int                        o_pending,
    output int                        o_checked
);
    timeunit 1ns;
    timeprecision 1ps;
    import dct_pkg::*;

    typedef struct packed {
        logic connected;
        logic out_of_range;
    } t_link_answer;

    logic [15:0]      label_tbl [NODES];
    logic [CNT_W-1:0] node_count_q;
    t_link_answer     answer_q [$];
    int               fail_cnt = 0;
    int               checked_cnt = 0;

    // node_count saturates at the table size
    function automatic int active_nodes();
        return (int'(node_count_q) > NODES) ? NODES : int'(node_count_q);
    endfunction

    function automatic bit node_in_use(input logic [NODE_W-1:0] n);
        return (n >= 1) && (int'(n) <= active_nodes());
    endfunction

    task automatic predict_request(input logic kind, input logic [NODE_W-1:0] a,
                                   input logic [NODE_W-1:0] b);
        t_link_answer ans;
        logic [15:0]  keep_lbl;
        logic [15:0]  drop_lbl;
        bit           both_ok;
        both_ok = node_in_use(a) && node_in_use(b);
        if (kind == KIND_QUERY) begin
            ans.out_of_range = !both_ok;
            ans.connected    = both_ok && (label_tbl[int'(a) - 1] == label_tbl[int'(b) - 1]);
            answer_q.push_back(ans);
        end else if (both_ok) begin
            keep_lbl = label_tbl[int'(a) - 1];
            drop_lbl = label_tbl[int'(b) - 1];
            // relabel across the whole table, not just the nodes in use
            if (keep_lbl != drop_lbl) begin
                for (int i = 0; i < NODES; i++) begin
                    if (label_tbl[i] == drop_lbl) label_tbl[i] = keep_lbl;
                end
            end
        end
    endtask

    task automatic check_answer(input logic connected, input logic out_of_range);
        t_link_answer want;
        if (answer_q.size() == 0) begin
            $display("%0t: result word with no query waiting: connected=%0b out_of_range=%0b",
                     $time, connected, out_of_range);
            fail_cnt++;
        end else begin
            want = answer_q.pop_front();
            checked_cnt++;
            if (connected !== want.connected) begin
                $display("%0t: connected mismatch: expected %0b, actual %0b",
                         $time, want.connected, connected);
                fail_cnt++;
            end
            if (out_of_range !== want.out_of_range) begin
                $display("%0t: out_of_range mismatch: expected %0b, actual %0b",
                         $time, want.out_of_range, out_of_range);
                fail_cnt++;
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NODES; i++) label_tbl[i] = 16'(i);
            node_count_q = NODE_COUNT_RST;
            answer_q.delete();
        end else begin
            if (i_cfg_wr_en) node_count_q = i_cfg_wr_data;
            if (i_res_mon.valid === 1'b1 && i_res_mon.ready === 1'b1) begin
                check_answer(i_res_mon.connected, i_res_mon.out_of_range);
            end
            if (i_req_mon.valid === 1'b1 && i_req_mon.ready === 1'b1) begin
                predict_request(i_req_mon.kind, i_req_mon.node_a, i_req_mon.node_b);
            end
        end
        o_fail_count <= fail_cnt;
        o_pending    <= answer_q.size();
        o_checked    <= checked_cnt;
    end

endmodule

FILE: dv/dynamic_connectivity_table_unit_tb.sv
// Testbench top: request stimulus, result stalls, config phases and verdict.
module dynamic_connectivity_table_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import dct_pkg::*;

    localparam int NODES          = 256;
    localparam int SETTLE_CYCLES  = 3 * (NODES + 8);
    localparam int SQUEEZE_CYCLES = 1500;
    localparam int CYCLE_LIMIT    = 1500000;

    logic             i_clk = 1'b0;
    logic             i_rst_n;
    logic             i_cfg_wr_en;
    logic [CNT_W-1:0] i_cfg_wr_data;

    dct_in_if  req_if ();
    dct_out_if res_if ();

    int fail_count;
    int results_pending;
    int results_checked;
    int cycle_cnt = 0;
    int connects_sent = 0;
    int queries_sent = 0;
    int settings_used = 0;
    bit tx_burst = 1'b0;
    bit rx_burst = 1'b0;
    bit squeeze_req = 1'b0;

    dynamic_connectivity_table_unit #(
        .NODES(NODES)
    ) u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_wr_data(i_cfg_wr_data),
        .i_in         (req_if.sink),
        .o_out        (res_if.source)
    );

    dct_link_checker #(
        .NODES(NODES)
    ) u_link_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_wr_data(i_cfg_wr_data),
        .i_req_mon    (req_if),
        .i_res_mon    (res_if),
        .o_fail_count (fail_count),
        .o_pending    (results_pending),
        .o_checked    (results_checked)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles", $time, cycle_cnt);
            $display("end of test: mismatches");
            $finish;
        end
    end

    // hold the request word until the unit takes it
    task automatic send_word(input logic kind, input logic [NODE_W-1:0] a,
                             input logic [NODE_W-1:0] b);
        int gap;
        gap = tx_burst ? 0 : $urandom_range(0, 16);
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_if.valid  <= 1'b1;
        req_if.kind   <= kind;
        req_if.node_a <= a;
        req_if.node_b <= b;
        do @(posedge i_clk); while (req_if.ready !== 1'b1);
        if (kind == KIND_CONNECT) connects_sent++;
        else queries_sent++;
        if ($urandom_range(0, 39) == 0) tx_burst = !tx_burst;
    endtask

    // drain all results, then give a merge scan time to finish
    task automatic settle();
        req_if.valid <= 1'b0;
        do @(posedge i_clk); while (results_pending != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_node_count(input logic [CNT_W-1:0] value);
        settle();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        settings_used++;
    endtask

    function automatic logic [NODE_W-1:0] pick_node(input int eff);
        int r;
        r = $urandom_range(0, 99);
        if (r < 7 || eff == 0) return NODE_W'($urandom_range(0, 511));
        if (r < 10) return NODE_W'(eff);
        if (r < 12) return NODE_W'(1);
        return NODE_W'($urandom_range(1, eff));
    endfunction

    task automatic run_phase(input logic [CNT_W-1:0] count_val, input int n_words,
                             input bit squeeze);
        int eff;
        write_node_count(count_val);
        eff = (int'(count_val) > NODES) ? NODES : int'(count_val);
        for (int n = 0; n < n_words; n++) begin
            if (squeeze && n == 10) squeeze_req = 1'b1;
            send_word(($urandom_range(0, 99) < 45) ? KIND_CONNECT : KIND_QUERY,
                      pick_node(eff), pick_node(eff));
        end
    endtask

    // result side: random stalls, one long hold-off on request
    initial begin
        int gap;
        res_if.ready <= 1'b0;
        do @(posedge i_clk); while (i_rst_n !== 1'b1);
        forever begin
            gap = rx_burst ? 0 : $urandom_range(0, 16);
            if (squeeze_req) begin
                squeeze_req = 1'b0;
                gap = SQUEEZE_CYCLES;
            end
            if (gap > 0) begin
                res_if.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            res_if.ready <= 1'b1;
            do @(posedge i_clk); while (res_if.valid !== 1'b1);
            if ($urandom_range(0, 31) == 0) rx_burst = !rx_burst;
        end
    end

    initial begin
        i_rst_n       <= 1'b0;
        i_cfg_wr_en   <= 1'b0;
        i_cfg_wr_data <= '0;
        req_if.valid  <= 1'b0;
        req_if.kind   <= KIND_QUERY;
        req_if.node_a <= '0;
        req_if.node_b <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed words at the reset node_count
        send_word(KIND_QUERY,   9'd1,   9'd1);
        send_word(KIND_QUERY,   9'd1,   9'd256);
        send_word(KIND_QUERY,   9'd0,   9'd5);
        send_word(KIND_QUERY,   9'd5,   9'd257);
        send_word(KIND_QUERY,   9'd511, 9'd511);
        send_word(KIND_CONNECT, 9'd1,   9'd256);
        send_word(KIND_QUERY,   9'd256, 9'd1);
        send_word(KIND_CONNECT, 9'd0,   9'd3);
        send_word(KIND_CONNECT, 9'd300, 9'd2);
        send_word(KIND_QUERY,   9'd3,   9'd1);
        send_word(KIND_CONNECT, 9'd2,   9'd2);
        send_word(KIND_CONNECT, 9'd2,   9'd1);
        send_word(KIND_QUERY,   9'd256, 9'd2);
        send_word(KIND_CONNECT, 9'd1,   9'd2);
        send_word(KIND_CONNECT, 9'd3,   9'd4);
        send_word(KIND_CONNECT, 9'd4,   9'd1);
        send_word(KIND_QUERY,   9'd3,   9'd256);
        send_word(KIND_QUERY,   9'd5,   9'd3);
        send_word(KIND_QUERY,   9'd255, 9'd254);

        run_phase(9'd1,   20,  1'b0);
        run_phase(9'd2,   30,  1'b0);
        run_phase(9'd0,   20,  1'b0);
        run_phase(9'd8,   80,  1'b0);
        run_phase(9'd511, 120, 1'b1);
        run_phase(9'd16,  80,  1'b0);
        run_phase(9'd300, 80,  1'b0);
        run_phase(9'd64,  120, 1'b0);
        run_phase(CNT_W'($urandom_range(1, 511)), 80, 1'b0);
        run_phase(9'd256, 150, 1'b0);
        run_phase(9'd4,   30,  1'b0);
        run_phase(9'd256, 40,  1'b0);
        settle();

        $display("covered %0d connect and %0d query words over %0d node_count settings",
                 connects_sent, queries_sent, settings_used);
        $display("checked %0d result words, %0d mismatching fields",
                 results_checked, fail_count);
        if (fail_count == 0 && results_pending == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

FILE: sim.f
sv/dct_pkg.sv
sv/dct_if.sv
sv/dct_front.sv
sv/dct_queue.sv
sv/dct_back.sv
sv/dynamic_connectivity_table_unit.sv
dv/dct_link_checker.sv
dv/dynamic_connectivity_table_unit_tb.sv
